### rtl/rte_pkg.sv
// rte_pkg: shared widths, codes and control types of the rrt tree extend engine
// used by rte_dsu and rrt_tree_extend_engine_top; no dependencies
package rte_pkg;

  localparam int COORD_W    = 16;
  localparam int STEP_W     = 15;
  localparam int STAT_W     = 3;
  localparam int IDX_OUT_W  = 10;
  localparam int DIFF_W     = 17;
  localparam int SQ_W       = 32;
  localparam int D2_W       = 33;
  localparam int RR_W       = 30;
  localparam int PROD_W     = 31;
  localparam int ROOT_W     = 27;
  localparam int DSU_IN_W   = 54;
  localparam int DIVISOR_W  = 28;
  localparam int ACC_W      = 43;
  localparam int REM_W      = 30;
  localparam int DSU_CNT_W  = 6;
  localparam int SQRT_STEPS = 27;
  localparam int DIV_STEPS  = 43;
  localparam int CFG_IDX_W  = 3;

  localparam logic [1:0] MODE_OBSTACLE = 2'd0;
  localparam logic [1:0] MODE_EXTEND   = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_COLLIDED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_TREE_FULL = 3'd2;
  localparam logic [STAT_W-1:0] ST_OBS_STORE = 3'd3;
  localparam logic [STAT_W-1:0] ST_OBS_FULL  = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd4;

  typedef struct packed {
    logic start;
    logic op_sqrt;
  } dsu_ctl_t;

endpackage

### rtl/rte_ram.sv
// rte_ram: generic single write port, single read port ram with registered read
// no dependencies
module rte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/rte_dsu.sv
// rte_dsu: shared iterative square root / divide unit, one result bit per cycle
// depends on rte_pkg
module rte_dsu (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rte_pkg::dsu_ctl_t                 ctl,
  input  logic [rte_pkg::DSU_IN_W-1:0]      operand,
  input  logic [rte_pkg::DIVISOR_W-1:0]     divisor,
  output logic                              done,
  output logic [rte_pkg::ACC_W-1:0]         result
);

  logic [rte_pkg::DSU_IN_W-1:0]  shift_r;
  logic [rte_pkg::REM_W-1:0]     rem_r;
  logic [rte_pkg::ACC_W-1:0]     acc_r;
  logic [rte_pkg::DIVISOR_W-1:0] divisor_r;
  logic [rte_pkg::DSU_CNT_W-1:0] cnt_r;
  logic                          sqrt_r;
  logic                          busy_r;
  logic                          done_r;

  logic [rte_pkg::REM_W-1:0]     rem_sh;
  logic [rte_pkg::REM_W-1:0]     trial;
  logic                          fits;

  // sqrt brings down two radicand bits, divide one
  assign rem_sh = sqrt_r ? {rem_r[rte_pkg::REM_W-3:0], shift_r[rte_pkg::DSU_IN_W-1 -: 2]}
                         : {rem_r[rte_pkg::REM_W-2:0], shift_r[rte_pkg::DSU_IN_W-1]};
  assign trial  = sqrt_r ? {acc_r[rte_pkg::REM_W-3:0], 2'b01}
                         : {{(rte_pkg::REM_W-rte_pkg::DIVISOR_W){1'b0}}, divisor_r};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.op_sqrt ? rte_pkg::DSU_CNT_W'(rte_pkg::SQRT_STEPS)
                              : rte_pkg::DSU_CNT_W'(rte_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - rte_pkg::DSU_CNT_W'(1);
        if (cnt_r == rte_pkg::DSU_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      shift_r   <= operand;
      rem_r     <= '0;
      acc_r     <= '0;
      sqrt_r    <= ctl.op_sqrt;
      divisor_r <= divisor;
    end else if (busy_r) begin
      rem_r   <= fits ? (rem_sh - trial) : rem_sh;
      acc_r   <= {acc_r[rte_pkg::ACC_W-2:0], fits};
      shift_r <= sqrt_r ? {shift_r[rte_pkg::DSU_IN_W-3:0], 2'b00}
                        : {shift_r[rte_pkg::DSU_IN_W-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("dsu done without a run");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(ctl.start) |-> !ctl.start) else $error("dsu restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("dsu done held");

endmodule

### rtl/rrt_tree_extend_engine_top.sv
// rrt_tree_extend_engine_top: sequencer, nearest-node scan and collision checks of the engine
// depends on rte_pkg, rte_ram (node and obstacle tables) and rte_dsu (sqrt and divide)
//
// usage: one item on the in_ channel, one result item on the out_ channel (mode 3 gives none).
// mode 0 stores an obstacle, mode 2 clears the tables and seeds node 0
// from start_x/start_y. mode 1 extends the tree:
//   nearest scan      one table read per cycle over all nodes, pipelined
//   step              square root, per axis a multiply and
//                     a divide, then the saturating add
//   obstacle checks   each stored obstacle until a hit, then add the node and test the goal
// in_ready is high only while the sequencer is idle; one item is worked on at a time.
// a finished result sits in an output register: a stalled receiver holds the sequencer
// at its last step, never a result in flight. cfg_ready is always high; registers are to
// be written by the user only while the block is idle, which the block itself does not
// enforce, and start_x/start_y take effect at the next clear. reset: sync active-low rst_n;
// node 0 is the start point (0, 0), one node, no obstacles, step_size 1.0; node 0 lives in
// registers so no table clearing pass is needed.
module rrt_tree_extend_engine_top #(
  parameter int MAX_NODES     = 1024,
  parameter int MAX_OBSTACLES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic signed [rte_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [rte_pkg::COORD_W-1:0]  in_point_y,
  input  logic [rte_pkg::STEP_W-1:0]          in_radius,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rte_pkg::STAT_W-1:0]          out_status,
  output logic [rte_pkg::IDX_OUT_W-1:0]       out_new_index,
  output logic [rte_pkg::IDX_OUT_W-1:0]       out_parent_index,
  output logic signed [rte_pkg::COORD_W-1:0]  out_new_x,
  output logic signed [rte_pkg::COORD_W-1:0]  out_new_y,
  output logic                                out_goal_reached,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rte_pkg::COORD_W-1:0]         cfg_data
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int OIDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int OCNT_W = $clog2(MAX_OBSTACLES + 1);
  localparam int CW     = rte_pkg::COORD_W;
  localparam int DW     = rte_pkg::DIFF_W;
  localparam int NODE_W = 2 * CW;
  localparam int OBS_W  = 2 * CW + rte_pkg::STEP_W;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_SCAN  = 15'b000000000000010,
    S_STEP  = 15'b000000000000100,
    S_ROOT  = 15'b000000000001000,
    S_MUL   = 15'b000000000010000,
    S_DIVS  = 15'b000000000100000,
    S_QUOT  = 15'b000000001000000,
    S_APPLY = 15'b000000010000000,
    S_ORD   = 15'b000000100000000,
    S_ODIFF = 15'b000001000000000,
    S_SQ    = 15'b000010000000000,
    S_CMP   = 15'b000100000000000,
    S_ADD   = 15'b001000000000000,
    S_GOAL  = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  state_t state_r;

  // configuration and tree bookkeeping
  logic signed [CW-1:0]          start_x_r, start_y_r, goal_x_r, goal_y_r;
  logic [rte_pkg::STEP_W-1:0]    step_r;
  logic signed [CW-1:0]          seed_x_r, seed_y_r;
  logic [CNT_W-1:0]              node_count_r;
  logic [OCNT_W-1:0]             obs_count_r;

  // item
  logic signed [CW-1:0]          px_r, py_r;

  // scan pipeline
  logic [CNT_W-1:0]              issue_r;
  logic                          s1_v_r, s2_v_r, s3_v_r;
  logic [IDX_W-1:0]              s1_idx_r, s2_idx_r, s3_idx_r;
  logic signed [CW-1:0]          s2_x_r, s2_y_r, s3_x_r, s3_y_r;
  logic signed [DW-1:0]          s2_dx_r, s2_dy_r, s3_dx_r, s3_dy_r;
  logic [rte_pkg::SQ_W-1:0]      s3_sqx_r, s3_sqy_r;
  logic [rte_pkg::D2_W-1:0]      best_d_r;
  logic [IDX_W-1:0]              best_idx_r;
  logic signed [CW-1:0]          best_x_r, best_y_r;
  logic signed [DW-1:0]          best_dx_r, best_dy_r;

  // step
  logic [rte_pkg::ROOT_W-1:0]    root_r;
  logic                          axis_r;
  logic [rte_pkg::PROD_W-1:0]    prod_r;
  logic signed [DW-1:0]          ox_r, oy_r;

  // obstacle and goal checks
  logic [OCNT_W-1:0]             oj_r;
  logic                          goal_ph_r;
  logic signed [DW-1:0]          ex_dx_r, ex_dy_r;
  logic [rte_pkg::RR_W-1:0]      rr_r;
  logic [rte_pkg::SQ_W-1:0]      sqx_r, sqy_r;

  // result
  logic [rte_pkg::STAT_W-1:0]    stat_r;
  logic [rte_pkg::IDX_OUT_W-1:0] nidx_r, pidx_r;
  logic signed [CW-1:0]          nx_r, ny_r;
  logic                          goal_r;
  logic                          out_valid_r;
  logic [rte_pkg::STAT_W-1:0]    out_status_r;
  logic [rte_pkg::IDX_OUT_W-1:0] out_nidx_r, out_pidx_r;
  logic signed [CW-1:0]          out_x_r, out_y_r;
  logic                          out_goal_r;

  // combinational
  logic                          in_acc, out_free, obs_full, tree_full;
  logic [NODE_W-1:0]             node_rdata;
  logic [OBS_W-1:0]              obs_rdata;
  logic                          node_we, obs_we;
  logic signed [CW-1:0]          s1_x, s1_y;
  logic signed [2*DW-1:0]        s2_px, s2_py, ex_px, ex_py;
  logic [rte_pkg::D2_W-1:0]      s3_d2, ex_d2;
  logic                          ex_le;
  rte_pkg::dsu_ctl_t             dsu_ctl;
  logic [rte_pkg::DSU_IN_W-1:0]  dsu_operand;
  logic [rte_pkg::ACC_W-1:0]     dsu_result;
  logic                          dsu_done;
  logic [rte_pkg::ACC_W-1:0]     dividend;
  logic signed [DW-1:0]          axis_d;
  logic                          axis_neg;
  logic [DW-1:0]                 axis_mag;
  logic signed [DW-1:0]          quot_s;
  logic signed [CW+1:0]          sum_x, sum_y;
  logic signed [CW-1:0]          sat_x, sat_y;
  logic [IDX_W+rte_pkg::IDX_OUT_W-1:0] best_ext, count_ext;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign obs_full  = (obs_count_r >= OCNT_W'(MAX_OBSTACLES));
  assign tree_full = (node_count_r >= CNT_W'(MAX_NODES));

  assign best_ext  = {{rte_pkg::IDX_OUT_W{1'b0}}, best_idx_r};
  assign count_ext = {{rte_pkg::IDX_OUT_W{1'b0}}, node_count_r[IDX_W-1:0]};

  // node 0 is held in registers, entries from 1 up in the table
  assign node_we = (state_r == S_ADD);
  assign obs_we  = in_acc && (in_mode == rte_pkg::MODE_OBSTACLE) && !obs_full;

  rte_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_count_r[IDX_W-1:0]),
    .wdata ({nx_r, ny_r}),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (node_rdata)
  );

  rte_ram #(.WIDTH(OBS_W), .DEPTH(MAX_OBSTACLES)) u_obs_ram (
    .clk   (clk),
    .we    (obs_we),
    .waddr (obs_count_r[OIDX_W-1:0]),
    .wdata ({in_point_x, in_point_y, in_radius}),
    .raddr (oj_r[OIDX_W-1:0]),
    .rdata (obs_rdata)
  );

  // scan datapath
  assign s1_x  = (s1_idx_r == '0) ? seed_x_r : node_rdata[NODE_W-1 -: CW];
  assign s1_y  = (s1_idx_r == '0) ? seed_y_r : node_rdata[CW-1:0];
  assign s2_px = s2_dx_r * s2_dx_r;
  assign s2_py = s2_dy_r * s2_dy_r;
  assign s3_d2 = {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};

  // obstacle and goal distance
  assign ex_px = ex_dx_r * ex_dx_r;
  assign ex_py = ex_dy_r * ex_dy_r;
  assign ex_d2 = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign ex_le = (ex_d2 <= {{(rte_pkg::D2_W-rte_pkg::RR_W){1'b0}}, rr_r});

  // step arithmetic
  assign axis_d   = axis_r ? best_dy_r : best_dx_r;
  assign axis_neg = axis_d[DW-1];
  assign axis_mag = axis_neg ? DW'(-axis_d) : DW'(axis_d);
  assign dividend = {1'b0, prod_r, 11'b0}
                  + {{(rte_pkg::ACC_W-rte_pkg::ROOT_W){1'b0}}, root_r};
  assign quot_s   = axis_neg ? -$signed({1'b0, dsu_result[CW-1:0]})
                             : $signed({1'b0, dsu_result[CW-1:0]});

  assign dsu_ctl.start   = ((state_r == S_STEP) && (best_d_r != '0)) || (state_r == S_DIVS);
  assign dsu_ctl.op_sqrt = (state_r == S_STEP);
  assign dsu_operand     = (state_r == S_STEP) ? {1'b0, best_d_r, 20'b0}
                                               : {dividend, 11'b0};

  rte_dsu u_dsu (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dsu_ctl),
    .operand (dsu_operand),
    .divisor ({root_r, 1'b0}),
    .done    (dsu_done),
    .result  (dsu_result)
  );

  assign sum_x = {{2{best_x_r[CW-1]}}, best_x_r} + {ox_r[DW-1], ox_r};
  assign sum_y = {{2{best_y_r[CW-1]}}, best_y_r} + {oy_r[DW-1], oy_r};

  always_comb begin
    if (sum_x > 18'sd32767) begin
      sat_x = 16'sh7fff;
    end else if (sum_x < -18'sd32768) begin
      sat_x = 16'sh8000;
    end else begin
      sat_x = sum_x[CW-1:0];
    end
    if (sum_y > 18'sd32767) begin
      sat_y = 16'sh7fff;
    end else if (sum_y < -18'sd32768) begin
      sat_y = 16'sh8000;
    end else begin
      sat_y = sum_y[CW-1:0];
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_x_r    <= '0;
      start_y_r    <= '0;
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      step_r       <= 15'd1024;
      seed_x_r     <= '0;
      seed_y_r     <= '0;
      node_count_r <= CNT_W'(1);
      obs_count_r  <= '0;
      issue_r      <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      axis_r       <= 1'b0;
      oj_r         <= '0;
      goal_ph_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rte_pkg::CFG_START_X: start_x_r <= cfg_data;
          rte_pkg::CFG_START_Y: start_y_r <= cfg_data;
          rte_pkg::CFG_GOAL_X:  goal_x_r  <= cfg_data;
          rte_pkg::CFG_GOAL_Y:  goal_y_r  <= cfg_data;
          rte_pkg::CFG_STEP:    step_r    <= cfg_data[rte_pkg::STEP_W-1:0];
          default: ;
        endcase
      end

      s1_v_r <= (state_r == S_SCAN) && (issue_r < node_count_r);
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;

      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (in_mode)
              rte_pkg::MODE_OBSTACLE: begin
                if (!obs_full) begin
                  obs_count_r <= obs_count_r + OCNT_W'(1);
                end
                state_r <= S_FIN;
              end
              rte_pkg::MODE_EXTEND: begin
                issue_r <= '0;
                state_r <= tree_full ? S_FIN : S_SCAN;
              end
              rte_pkg::MODE_CLEAR: begin
                seed_x_r     <= start_x_r;
                seed_y_r     <= start_y_r;
                node_count_r <= CNT_W'(1);
                obs_count_r  <= '0;
                state_r      <= S_FIN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (issue_r < node_count_r) begin
            issue_r <= issue_r + CNT_W'(1);
          end else if (!s1_v_r && !s2_v_r && !s3_v_r) begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          axis_r  <= 1'b0;
          state_r <= (best_d_r == '0) ? S_APPLY : S_ROOT;
        end
        S_ROOT: begin
          if (dsu_done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL:  state_r <= S_DIVS;
        S_DIVS: state_r <= S_QUOT;
        S_QUOT: begin
          if (dsu_done) begin
            axis_r  <= 1'b1;
            state_r <= axis_r ? S_APPLY : S_MUL;
          end
        end
        S_APPLY: begin
          oj_r      <= '0;
          goal_ph_r <= 1'b0;
          state_r   <= S_ORD;
        end
        S_ORD:   state_r <= (oj_r < obs_count_r) ? S_ODIFF : S_ADD;
        S_ODIFF: state_r <= S_SQ;
        S_SQ:    state_r <= S_CMP;
        S_CMP: begin
          if (goal_ph_r || ex_le) begin
            state_r <= S_FIN;
          end else begin
            oj_r    <= oj_r + OCNT_W'(1);
            state_r <= S_ORD;
          end
        end
        S_ADD: begin
          node_count_r <= node_count_r + CNT_W'(1);
          state_r      <= S_GOAL;
        end
        S_GOAL: begin
          goal_ph_r <= 1'b1;
          state_r   <= S_SQ;
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // nearest-node scan pipeline
    s1_idx_r <= issue_r[IDX_W-1:0];
    s2_idx_r <= s1_idx_r;
    s2_x_r   <= s1_x;
    s2_y_r   <= s1_y;
    s2_dx_r  <= $signed({px_r[CW-1], px_r}) - $signed({s1_x[CW-1], s1_x});
    s2_dy_r  <= $signed({py_r[CW-1], py_r}) - $signed({s1_y[CW-1], s1_y});
    s3_idx_r <= s2_idx_r;
    s3_x_r   <= s2_x_r;
    s3_y_r   <= s2_y_r;
    s3_dx_r  <= s2_dx_r;
    s3_dy_r  <= s2_dy_r;
    s3_sqx_r <= s2_px[rte_pkg::SQ_W-1:0];
    s3_sqy_r <= s2_py[rte_pkg::SQ_W-1:0];
    // first node at the least distance wins ties
    if (s3_v_r && ((s3_idx_r == '0) || (s3_d2 < best_d_r))) begin
      best_d_r   <= s3_d2;
      best_idx_r <= s3_idx_r;
      best_x_r   <= s3_x_r;
      best_y_r   <= s3_y_r;
      best_dx_r  <= s3_dx_r;
      best_dy_r  <= s3_dy_r;
    end

    sqx_r <= ex_px[rte_pkg::SQ_W-1:0];
    sqy_r <= ex_py[rte_pkg::SQ_W-1:0];

    case (state_r)
      S_IDLE: begin
        px_r   <= in_point_x;
        py_r   <= in_point_y;
        nidx_r <= '0;
        pidx_r <= '0;
        goal_r <= 1'b0;
        nx_r   <= '0;
        ny_r   <= '0;
        case (in_mode)
          rte_pkg::MODE_OBSTACLE: stat_r <= obs_full ? rte_pkg::ST_OBS_FULL
                                                     : rte_pkg::ST_OBS_STORE;
          rte_pkg::MODE_EXTEND:   stat_r <= rte_pkg::ST_TREE_FULL;
          rte_pkg::MODE_CLEAR: begin
            stat_r <= rte_pkg::ST_CLEARED;
            nx_r   <= start_x_r;
            ny_r   <= start_y_r;
          end
          default: ;
        endcase
      end
      S_STEP: begin
        pidx_r <= best_ext[rte_pkg::IDX_OUT_W-1:0];
        // coincident points step along +x
        ox_r   <= DW'(step_r);
        oy_r   <= '0;
      end
      S_ROOT: begin
        if (dsu_done) begin
          root_r <= dsu_result[rte_pkg::ROOT_W-1:0];
        end
      end
      S_MUL: begin
        prod_r <= step_r * axis_mag[CW-1:0];
      end
      S_QUOT: begin
        if (dsu_done) begin
          if (axis_r) begin
            oy_r <= quot_s;
          end else begin
            ox_r <= quot_s;
          end
        end
      end
      S_APPLY: begin
        nx_r <= sat_x;
        ny_r <= sat_y;
      end
      S_ODIFF: begin
        ex_dx_r <= $signed({obs_rdata[OBS_W-1], obs_rdata[OBS_W-1 -: CW]})
                 - $signed({nx_r[CW-1], nx_r});
        ex_dy_r <= $signed({obs_rdata[OBS_W-CW-1], obs_rdata[OBS_W-CW-1 -: CW]})
                 - $signed({ny_r[CW-1], ny_r});
        rr_r    <= obs_rdata[rte_pkg::STEP_W-1:0] * obs_rdata[rte_pkg::STEP_W-1:0];
      end
      S_CMP: begin
        if (goal_ph_r) begin
          goal_r <= ex_le;
          stat_r <= rte_pkg::ST_ADDED;
        end else if (ex_le) begin
          stat_r <= rte_pkg::ST_COLLIDED;
        end
      end
      S_ADD: begin
        nidx_r <= count_ext[rte_pkg::IDX_OUT_W-1:0];
      end
      S_GOAL: begin
        ex_dx_r <= $signed({nx_r[CW-1], nx_r}) - $signed({goal_x_r[CW-1], goal_x_r});
        ex_dy_r <= $signed({ny_r[CW-1], ny_r}) - $signed({goal_y_r[CW-1], goal_y_r});
        rr_r    <= step_r * step_r;
      end
      default: ;
    endcase

    if (state_r == S_FIN && out_free) begin
      out_status_r <= stat_r;
      out_nidx_r   <= nidx_r;
      out_pidx_r   <= pidx_r;
      out_x_r      <= nx_r;
      out_y_r      <= ny_r;
      out_goal_r   <= goal_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_new_index    = out_nidx_r;
  assign out_parent_index = out_pidx_r;
  assign out_new_x        = out_x_r;
  assign out_new_y        = out_y_r;
  assign out_goal_reached = out_goal_r;

  a_node_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (node_count_r != '0) && (node_count_r <= CNT_W'(MAX_NODES)))
    else $error("node count out of range");
  a_obs_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    obs_count_r <= OCNT_W'(MAX_OBSTACLES)) else $error("obstacle count out of range");
  a_clear_seeds: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode == rte_pkg::MODE_CLEAR)
    |=> (node_count_r == CNT_W'(1)) && (obs_count_r == '0))
    else $error("clear did not reset the tables");
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode != rte_pkg::MODE_NONE) |=> !in_ready)
    else $error("item accepted while work pending");
  a_add_grows_tree: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |=> (node_count_r == $past(node_count_r) + CNT_W'(1)))
    else $error("node add did not advance count");

endmodule

### sim/tb.sv
// tb: self-checking testbench of rrt_tree_extend_engine_top, directed table then random items
// depends on rte_pkg and the engine rtl; predicts each result with a local tree model
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES_MAX = 1024;
  localparam int OBS_MAX   = 16;
  localparam longint CYCLE_LIMIT = 64'd2_000_000;

  typedef struct packed {
    logic [rte_pkg::STAT_W-1:0]    status;
    logic [rte_pkg::IDX_OUT_W-1:0] new_index;
    logic [rte_pkg::IDX_OUT_W-1:0] parent_index;
    logic [rte_pkg::COORD_W-1:0]   new_x;
    logic [rte_pkg::COORD_W-1:0]   new_y;
    logic                          goal_reached;
  } tree_result_t;

  typedef struct {
    logic [1:0]                  mode;
    logic [rte_pkg::COORD_W-1:0] px;
    logic [rte_pkg::COORD_W-1:0] py;
    logic [rte_pkg::STEP_W-1:0]  rad;
    bit                          has_exp;
    tree_result_t                exp_res;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [1:0] in_mode;
  logic signed [rte_pkg::COORD_W-1:0] in_point_x, in_point_y;
  logic [rte_pkg::STEP_W-1:0] in_radius;
  logic [rte_pkg::STAT_W-1:0] out_status;
  logic [rte_pkg::IDX_OUT_W-1:0] out_new_index, out_parent_index;
  logic signed [rte_pkg::COORD_W-1:0] out_new_x, out_new_y;
  logic out_goal_reached;
  logic [rte_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rte_pkg::COORD_W-1:0] cfg_data;

  rrt_tree_extend_engine_top DUT (.*);

  // local copy of the tree and registers
  longint tr_sx, tr_sy, tr_gx, tr_gy, tr_step;
  longint tr_nx[NODES_MAX];
  longint tr_ny[NODES_MAX];
  int     tr_count;
  longint ob_cx[OBS_MAX];
  longint ob_cy[OBS_MAX];
  longint ob_r[OBS_MAX];
  int     ob_count;

  tree_result_t pending_results[$];
  int  errors = 0;
  bit  hold_off = 0;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint step_offset(longint d, longint r);
    longint m, q;
    m = d < 0 ? -d : d;
    q = (2 * tr_step * m * 1024 + r) / (2 * r);
    return d < 0 ? -q : q;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void tree_reseed();
    tr_nx[0] = tr_sx;
    tr_ny[0] = tr_sy;
    tr_count = 1;
    ob_count = 0;
  endfunction

  function automatic void tree_write_reg(logic [rte_pkg::CFG_IDX_W-1:0] idx,
                                         logic [rte_pkg::COORD_W-1:0] val);
    case (idx)
      rte_pkg::CFG_START_X: tr_sx = longint'($signed(val));
      rte_pkg::CFG_START_Y: tr_sy = longint'($signed(val));
      rte_pkg::CFG_GOAL_X:  tr_gx = longint'($signed(val));
      rte_pkg::CFG_GOAL_Y:  tr_gy = longint'($signed(val));
      rte_pkg::CFG_STEP:    tr_step = longint'(val[rte_pkg::STEP_W-1:0]);
      default: ;
    endcase
  endfunction

  // returns 0 when the item gives no result
  function automatic bit tree_predict(logic [1:0] mode, logic [rte_pkg::COORD_W-1:0] pxr,
                                      logic [rte_pkg::COORD_W-1:0] pyr,
                                      logic [rte_pkg::STEP_W-1:0] rad,
                                      output tree_result_t res);
    longint px, py, bd, d2, dx, dy, ox, oy, nx, ny, r;
    int best;
    bit hit;
    px = longint'($signed(pxr));
    py = longint'($signed(pyr));
    res = '0;
    if (mode == rte_pkg::MODE_NONE) return 0;
    if (mode == rte_pkg::MODE_OBSTACLE) begin
      if (ob_count >= OBS_MAX) res.status = rte_pkg::ST_OBS_FULL;
      else begin
        ob_cx[ob_count] = px;
        ob_cy[ob_count] = py;
        ob_r[ob_count] = rad;
        ob_count++;
        res.status = rte_pkg::ST_OBS_STORE;
      end
    end else if (mode == rte_pkg::MODE_CLEAR) begin
      tree_reseed();
      res.status = rte_pkg::ST_CLEARED;
      res.new_x = tr_sx[15:0];
      res.new_y = tr_sy[15:0];
    end else if (tr_count >= NODES_MAX) begin
      res.status = rte_pkg::ST_TREE_FULL;
    end else begin
      best = 0;
      bd = 0;
      for (int i = 0; i < tr_count; i++) begin
        d2 = sq_dist(tr_nx[i], tr_ny[i], px, py);
        if (i == 0 || d2 < bd) begin
          bd = d2;
          best = i;
        end
      end
      dx = px - tr_nx[best];
      dy = py - tr_ny[best];
      if (bd == 0) begin
        ox = tr_step;
        oy = 0;
      end else begin
        r = int_sqrt(bd * 1048576);
        ox = step_offset(dx, r);
        oy = step_offset(dy, r);
      end
      nx = clip16(tr_nx[best] + ox);
      ny = clip16(tr_ny[best] + oy);
      res.parent_index = best[rte_pkg::IDX_OUT_W-1:0];
      res.new_x = nx[15:0];
      res.new_y = ny[15:0];
      hit = 0;
      for (int i = 0; i < ob_count; i++)
        if (sq_dist(ob_cx[i], ob_cy[i], nx, ny) <= ob_r[i] * ob_r[i]) hit = 1;
      if (hit) res.status = rte_pkg::ST_COLLIDED;
      else begin
        res.status = rte_pkg::ST_ADDED;
        res.new_index = tr_count[rte_pkg::IDX_OUT_W-1:0];
        tr_nx[tr_count] = nx;
        tr_ny[tr_count] = ny;
        tr_count++;
        res.goal_reached = sq_dist(nx, ny, tr_gx, tr_gy) <= tr_step * tr_step;
      end
    end
    return 1;
  endfunction

  task automatic send_item(logic [1:0] mode, logic [rte_pkg::COORD_W-1:0] px,
                           logic [rte_pkg::COORD_W-1:0] py, logic [rte_pkg::STEP_W-1:0] rad,
                           bit has_exp, tree_result_t exp_res);
    tree_result_t res;
    in_valid = 1;
    in_mode = mode;
    in_point_x = px;
    in_point_y = py;
    in_radius = rad;
    do @(posedge clk); while (!in_ready);
    if (tree_predict(mode, px, py, rad, res)) begin
      if (has_exp && res != exp_res) begin
        $error("table row mismatch: expected %h predicted %h", exp_res, res);
        errors++;
      end
      pending_results.insert(pending_results.size(), has_exp ? exp_res : res);
    end
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic sender_gap();
    int n;
    if ($urandom_range(0, 2) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    // let the last item settle before any register write
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [rte_pkg::CFG_IDX_W-1:0] idx,
                           logic [rte_pkg::COORD_W-1:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    tree_write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // receiver
  initial begin
    int n;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
        repeat (n) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    tree_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_status, out_new_index, out_parent_index, out_new_x, out_new_y,
             out_goal_reached};
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %h", got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status); errors++;
        end
        if (got.new_index != want.new_index) begin
          $error("new_index expected %0d actual %0d", want.new_index, got.new_index); errors++;
        end
        if (got.parent_index != want.parent_index) begin
          $error("parent_index expected %0d actual %0d", want.parent_index,
                 got.parent_index); errors++;
        end
        if (got.new_x != want.new_x) begin
          $error("new_x expected %h actual %h", want.new_x, got.new_x); errors++;
        end
        if (got.new_y != want.new_y) begin
          $error("new_y expected %h actual %h", want.new_y, got.new_y); errors++;
        end
        if (got.goal_reached != want.goal_reached) begin
          $error("goal_reached expected %0d actual %0d", want.goal_reached,
                 got.goal_reached); errors++;
        end
      end
    end
  end

  function automatic tree_result_t mk(logic [2:0] st, int ni, int pi, int x, int y, bit g);
    tree_result_t r;
    r.status = st;
    r.new_index = ni[9:0];
    r.parent_index = pi[9:0];
    r.new_x = x[15:0];
    r.new_y = y[15:0];
    r.goal_reached = g;
    return r;
  endfunction

  function automatic logic [15:0] rnd_coord(int spread);
    int v;
    v = $urandom_range(0, 2 * spread) - spread;
    return v[15:0];
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    tree_result_t none;
    int n;
    logic [1:0] m;
    none = '0;
    rst_n = 0;
    in_valid = 0; in_mode = rte_pkg::MODE_NONE; in_point_x = 0; in_point_y = 0;
    in_radius = 0;
    cfg_valid = 0; cfg_index = rte_pkg::CFG_START_X; cfg_data = 0;
    tr_sx = 0; tr_sy = 0; tr_gx = 0; tr_gy = 0; tr_step = 1024;
    tree_reseed();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed table: coincident sample from reset, extremes, obstacles, mode 3
    rows = '{
      '{rte_pkg::MODE_EXTEND, 16'h0000, 16'h0000, 15'd0, 1,
        mk(rte_pkg::ST_ADDED, 1, 0, 1024, 0, 1)},
      '{rte_pkg::MODE_EXTEND, 16'h7fff, 16'h0000, 15'd0, 1,
        mk(rte_pkg::ST_ADDED, 2, 1, 2048, 0, 0)},
      '{rte_pkg::MODE_EXTEND, 16'h8000, 16'h8000, 15'd0, 0, none},
      '{rte_pkg::MODE_EXTEND, 16'h0000, 16'h7fff, 15'd0, 0, none},
      '{rte_pkg::MODE_NONE,   16'hffff, 16'hffff, 15'h7fff, 0, none},
      '{rte_pkg::MODE_OBSTACLE, 16'h0c00, 16'h0000, 15'd600, 1,
        mk(rte_pkg::ST_OBS_STORE, 0, 0, 0, 0, 0)},
      '{rte_pkg::MODE_EXTEND, 16'h7fff, 16'h0000, 15'd0, 0, none},
      '{rte_pkg::MODE_OBSTACLE, 16'h8000, 16'h7fff, 15'h7fff, 1,
        mk(rte_pkg::ST_OBS_STORE, 0, 0, 0, 0, 0)},
      '{rte_pkg::MODE_EXTEND, 16'h8000, 16'h0000, 15'd0, 0, none},
      '{rte_pkg::MODE_CLEAR,  16'h1234, 16'h5678, 15'd5, 1,
        mk(rte_pkg::ST_CLEARED, 0, 0, 0, 0, 0)},
      '{rte_pkg::MODE_EXTEND, 16'hfc00, 16'h0400, 15'd0, 0, none},
      '{rte_pkg::MODE_EXTEND, 16'h0400, 16'h0400, 15'd0, 0, none}
    };
    for (int i = 0; i < 16; i++) begin
      row = '{rte_pkg::MODE_OBSTACLE, 16'h7000, 16'h7000, 15'd1, 0, none};
      rows.insert(rows.size(), row);
    end
    // one obstacle past the table size
    row = '{rte_pkg::MODE_OBSTACLE, 16'h7000, 16'h7000, 15'd1, 1,
            mk(rte_pkg::ST_OBS_FULL, 0, 0, 0, 0, 0)};
    rows.insert(rows.size(), row);
    row = '{rte_pkg::MODE_EXTEND, 16'h0000, 16'h0000, 15'd0, 0, none};
    rows.insert(rows.size(), row);
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.mode, row.px, row.py, row.rad, row.has_exp, row.exp_res);
    end
    drain();

    // settings sweep with extremes, each phase restarting the tree
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(rte_pkg::CFG_STEP, 16'h7fff);
                 write_reg(rte_pkg::CFG_START_X, 16'h8000);
                 write_reg(rte_pkg::CFG_START_Y, 16'h7fff);
                 write_reg(rte_pkg::CFG_GOAL_X, 16'h7fff);
                 write_reg(rte_pkg::CFG_GOAL_Y, 16'h8000); end
        1: begin write_reg(rte_pkg::CFG_STEP, 16'h0000);
                 write_reg(rte_pkg::CFG_START_X, 16'h7fff);
                 write_reg(rte_pkg::CFG_START_Y, 16'h8000); end
        2: begin write_reg(rte_pkg::CFG_STEP, 16'h0001);
                 write_reg(rte_pkg::CFG_START_X, 16'h0000);
                 write_reg(rte_pkg::CFG_START_Y, 16'h0000);
                 write_reg(rte_pkg::CFG_GOAL_X, 16'h0000);
                 write_reg(rte_pkg::CFG_GOAL_Y, 16'h0000); end
        default: begin
          write_reg(rte_pkg::CFG_STEP, {1'b0, 15'($urandom_range(256, 6000))});
          write_reg(rte_pkg::CFG_START_X, rnd_coord(8000));
          write_reg(rte_pkg::CFG_START_Y, rnd_coord(8000));
          write_reg(rte_pkg::CFG_GOAL_X, rnd_coord(20000));
          write_reg(rte_pkg::CFG_GOAL_Y, rnd_coord(20000));
        end
      endcase
      send_item(rte_pkg::MODE_CLEAR, 16'($urandom), 16'($urandom), 15'($urandom), 0, none);
      n = $urandom_range(0, 5);
      for (int k = 0; k < n; k++)
        send_item(rte_pkg::MODE_OBSTACLE, rnd_coord(30000), rnd_coord(30000),
                  15'($urandom_range(0, 4000)), 0, none);
      if (ph == 3) hold_off = 1;
      for (int k = 0; k < 82; k++) begin
        m = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : rte_pkg::MODE_EXTEND;
        if (m == rte_pkg::MODE_CLEAR && $urandom_range(0, 1)) m = rte_pkg::MODE_EXTEND;
        send_item(m, ($urandom_range(0, 7) == 0) ? 16'($urandom) : rnd_coord(12000),
                  ($urandom_range(0, 7) == 0) ? 16'($urandom) : rnd_coord(12000),
                  15'($urandom), 0, none);
        sender_gap();
        if (k == 45) drain();
      end
      drain();
    end

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
